### hdl/dpd_pkg.sv
package dpd_pkg;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharEscape = 8'h7D;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharBreak  = 8'h03;
  localparam logic [7:0] EscapeXor  = 8'h20;

  typedef enum logic [2:0] {
    ModeIdle = 3'd0,
    ModeBody = 3'd1,
    ModeEsc  = 3'd2,
    ModeCk1  = 3'd3,
    ModeCk2  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    EvPayload = 3'd0,
    EvAccept  = 3'd1,
    EvReject  = 3'd2,
    EvDrop    = 3'd3,
    EvAck     = 3'd4,
    EvNak     = 3'd5,
    EvBreak   = 3'd6,
    EvUnexp   = 3'd7
  } event_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] running_sum;
    logic [3:0] high_digit;
    logic       digit_error;
    logic       payload_seen;
  } state_t;

  typedef struct packed {
    logic       valid;
    event_e     ev;
    logic [7:0] value;
  } result_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nib;
  } hex_t;

  // A byte that is not a hex digit decodes as zero and is flagged bad.
  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t r;
    r.bad = 1'b0;
    r.nib = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.nib = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r.nib = 4'(b[3:0] + 4'd9);
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

### hdl/debug_packet_deframer.sv
// Receiver for debug-link packets framed as '$' body '#' hex hex. One received byte is
// taken per transaction and each byte gives at most one result: a payload byte (escapes
// removed), accept or reject with the received checksum, a dropped partial packet, a peer
// ack or nak, a break, or an unexpected byte. A byte passes through an input register and
// the decode logic into the result register, so results are registered, and one byte per
// cycle is sustained; the input stalls only while the result register holds a transaction
// that the output side has not yet taken.
module debug_packet_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_res_o,
  output logic [7:0] value_o
);
  import dpd_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_free;
  logic       advance;
  result_t    res;

  assign advance = s1_valid && out_free;

  dpd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  dpd_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (s1_byte),
    .res_o  (res)
  );

  dpd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_res_o (event_res_o),
    .value_o     (value_o)
  );

endmodule

### hdl/dpd_in_stage.sv
module dpd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_stall_o = valid_q && !advance_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

### hdl/dpd_fsm.sv
module dpd_fsm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output dpd_pkg::result_t res_o
);
  import dpd_pkg::*;

  state_t     state_q;
  state_t     state_d;
  hex_t       hex;
  logic [7:0] sum_plus;
  logic [7:0] rx_sum;
  logic       bad;

  assign hex      = hex_decode(byte_i);
  assign sum_plus = state_q.running_sum + byte_i;
  assign rx_sum   = {state_q.high_digit, hex.nib};
  assign bad      = state_q.digit_error || hex.bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: ModeIdle, running_sum: 8'h00, high_digit: 4'h0,
                   digit_error: 1'b0, payload_seen: 1'b0};
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    res_o.valid = 1'b0;
    res_o.ev    = EvPayload;
    res_o.value = byte_i;
    unique case (state_q.mode)
      ModeBody: begin
        if (byte_i == CharDollar) begin
          state_d.running_sum  = 8'h00;
          state_d.payload_seen = 1'b0;
          res_o.valid          = state_q.payload_seen;
          res_o.ev             = EvDrop;
        end else if (byte_i == CharEscape) begin
          state_d.running_sum = sum_plus;
          state_d.mode        = ModeEsc;
        end else if (byte_i == CharHash) begin
          state_d.digit_error = 1'b0;
          state_d.high_digit  = 4'h0;
          state_d.mode        = ModeCk1;
        end else begin
          state_d.running_sum  = sum_plus;
          state_d.payload_seen = 1'b1;
          res_o.valid          = 1'b1;
        end
      end
      ModeEsc: begin
        state_d.running_sum  = sum_plus;
        state_d.payload_seen = 1'b1;
        state_d.mode         = ModeBody;
        res_o.valid          = 1'b1;
        res_o.value          = byte_i ^ EscapeXor;
      end
      ModeCk1: begin
        state_d.high_digit  = hex.nib;
        state_d.digit_error = hex.bad;
        state_d.mode        = ModeCk2;
      end
      ModeCk2: begin
        state_d.mode        = ModeIdle;
        state_d.digit_error = 1'b0;
        res_o.valid         = 1'b1;
        res_o.value         = rx_sum;
        res_o.ev            = (!bad && rx_sum == state_q.running_sum) ? EvAccept : EvReject;
      end
      default: begin
        state_d.mode = ModeIdle;
        if (byte_i == CharDollar) begin
          state_d.mode         = ModeBody;
          state_d.running_sum  = 8'h00;
          state_d.payload_seen = 1'b0;
        end else begin
          res_o.valid = 1'b1;
          if (byte_i == CharPlus) begin
            res_o.ev = EvAck;
          end else if (byte_i == CharMinus) begin
            res_o.ev = EvNak;
          end else if (byte_i == CharBreak) begin
            res_o.ev = EvBreak;
          end else begin
            res_o.ev = EvUnexp;
          end
        end
      end
    endcase
  end

endmodule

### hdl/dpd_out_stage.sv
module dpd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  dpd_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       event_res_o,
  output logic [7:0]       value_o
);
  import dpd_pkg::*;

  logic       valid_q;
  logic [2:0] event_q;
  logic [7:0] value_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign event_res_o = event_q;
  assign value_o     = value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= res_i.valid;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && res_i.valid) begin
      event_q <= 3'(res_i.ev);
      value_q <= res_i.value;
    end
  end

endmodule
